[rtl/swa_pkg.sv]
// shared types and constants for the sliding window average block
`default_nettype none

package swa_pkg;

   localparam int CSR_BITS = 7;
   localparam logic [CSR_BITS-1:0] WINDOW_LEN_RESET = 7'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SWEEP,
      ST_LOAD,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic sweep_init;
      logic sweep_step;
      logic div_load;
      logic div_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic dirty;
      logic sweep_done;
      logic fill_ok;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/swa_if.sv]
// stream interfaces for the sample and result channels
`default_nettype none

interface swa_req_if #(parameter int WIDTH = 16) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface swa_rsp_if #(parameter int WIDTH = 16) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink (input valid, input average, output ready);
endinterface

`default_nettype wire

[rtl/swa_ctrl.sv]
// controller state machine sequencing update, resum sweep, divide and result
`default_nettype none

module swa_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  swa_pkg::status_type  status,
   output swa_pkg::cmd_type     cmd
);

   swa_pkg::state_type state_ff;
   swa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         swa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = swa_pkg::ST_UPDATE;
            end
         end
         swa_pkg::ST_UPDATE: begin
            cmd.update     = 1'b1;
            cmd.sweep_init = status.dirty;
            state_in       = status.dirty ? swa_pkg::ST_SWEEP : swa_pkg::ST_LOAD;
         end
         swa_pkg::ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_done) begin
               state_in = swa_pkg::ST_LOAD;
            end
         end
         swa_pkg::ST_LOAD: begin
            cmd.div_load = 1'b1;
            // too few samples for the window: no result
            state_in     = status.fill_ok ? swa_pkg::ST_DIV : swa_pkg::ST_IDLE;
         end
         swa_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = swa_pkg::ST_EMIT;
            end
         end
         swa_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = swa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swa_pkg::ST_IDLE;
         end
      endcase
   end

   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == swa_pkg::ST_UPDATE)
      else $error("accepted transfer did not move to update");

   a_emit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == swa_pkg::ST_EMIT && status.out_free |=> state_ff == swa_pkg::ST_IDLE)
      else $error("result not released when output register free");

   a_div_done_to_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step && status.div_done |=> state_ff == swa_pkg::ST_EMIT)
      else $error("finished division did not reach emit");

endmodule

`default_nettype wire

[rtl/swa_datapath.sv]
// sample ring, running sum, serial divider and result register
`default_nettype none

module swa_datapath #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  swa_pkg::cmd_type                     cmd,
   output swa_pkg::status_type                  status,
   input  wire                                  csr_write_en,
   input  wire [swa_pkg::CSR_BITS-1:0]          csr_write_data,
   input  wire signed [SAMPLE_BITS-1:0]         req_sample,
   input  wire                                  rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]        rsp_average
);

   localparam int PTR_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WIN_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
   localparam int MAG_BITS  = SUM_BITS - 1;
   localparam int DCNT_BITS = $clog2(MAG_BITS);
   localparam int OLD_BITS  = WIN_BITS + 1;
   localparam longint SUM_HI = longint'(MAX_WINDOW) * ((longint'(1) << (SAMPLE_BITS - 1)) - 1);
   localparam longint SUM_LO = -(longint'(MAX_WINDOW) * (longint'(1) << (SAMPLE_BITS - 1)));

   // configuration
   logic [swa_pkg::CSR_BITS-1:0] win_len_ff;
   logic [WIN_BITS-1:0]          win_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= swa_pkg::WINDOW_LEN_RESET;
      end else if (csr_write_en) begin
         win_len_ff <= csr_write_data;
      end
   end

   always_comb begin
      priority if (win_len_ff == '0) begin
         win_eff = WIN_BITS'(1);
      end else if (32'(win_len_ff) > MAX_WINDOW) begin
         win_eff = WIN_BITS'(MAX_WINDOW);
      end else begin
         win_eff = WIN_BITS'(win_len_ff);
      end
   end

   // ring and its pointers
   logic [SAMPLE_BITS-1:0]        ring_mem [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic [PTR_BITS-1:0]           write_slot_ff;
   logic [PTR_BITS-1:0]           write_slot_in;
   logic [WIN_BITS-1:0]           fill_ff;
   logic [WIN_BITS-1:0]           fill_in;
   logic [OLD_BITS-1:0]           old_raw;
   logic [PTR_BITS-1:0]           old_slot;
   logic [PTR_BITS-1:0]           rd_addr;

   // slot holding the sample that leaves the window
   always_comb begin
      old_raw = OLD_BITS'(write_slot_ff) + OLD_BITS'(MAX_WINDOW) - OLD_BITS'(win_eff);
      if (old_raw >= OLD_BITS'(MAX_WINDOW)) begin
         old_slot = PTR_BITS'(old_raw - OLD_BITS'(MAX_WINDOW));
      end else begin
         old_slot = PTR_BITS'(old_raw);
      end
   end

   always_comb begin
      write_slot_in = (write_slot_ff == PTR_BITS'(MAX_WINDOW - 1)) ? '0
                                                                  : write_slot_ff + 1'b1;
      fill_in       = (fill_ff == WIN_BITS'(MAX_WINDOW)) ? fill_ff : fill_ff + 1'b1;
   end

   // sweep that rebuilds the sum after a window length change
   logic [PTR_BITS-1:0] sweep_ptr_ff;
   logic [WIN_BITS-1:0] sweep_cnt_ff;
   logic                pend_ff;
   logic                sweep_issue;
   logic                dirty_ff;

   assign sweep_issue = sweep_cnt_ff < win_eff;
   assign rd_addr     = cmd.sweep_step ? sweep_ptr_ff : old_slot;

   always_ff @(posedge clock) begin
      rd_data_ff <= ring_mem[rd_addr];
      if (cmd.update) begin
         ring_mem[write_slot_ff] <= sample_ff;
      end
      if (cmd.accept) begin
         sample_ff <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         fill_ff       <= '0;
         dirty_ff      <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         if (cmd.update) begin
            write_slot_ff <= write_slot_in;
            fill_ff       <= fill_in;
         end
         priority if (csr_write_en) begin
            dirty_ff <= 1'b1;
         end else if (cmd.sweep_step && status.sweep_done) begin
            dirty_ff <= 1'b0;
         end else begin
            dirty_ff <= dirty_ff;
         end
         pend_ff <= cmd.sweep_step && sweep_issue && (sweep_cnt_ff < fill_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_init) begin
         // newest sample sits in the slot just written
         sweep_ptr_ff <= write_slot_ff;
         sweep_cnt_ff <= '0;
      end else if (cmd.sweep_step && sweep_issue) begin
         sweep_ptr_ff <= (sweep_ptr_ff == '0) ? PTR_BITS'(MAX_WINDOW - 1)
                                              : sweep_ptr_ff - 1'b1;
         sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
      end
   end

   // running sum
   logic signed [SUM_BITS-1:0] sum_ff;
   logic signed [SUM_BITS-1:0] sum_in;
   logic signed [SUM_BITS-1:0] old_term;

   always_comb begin
      old_term = (fill_ff >= win_eff) ? SUM_BITS'(rd_data_ff) : SUM_BITS'(0);
      priority if (cmd.sweep_init) begin
         sum_in = '0;
      end else if (cmd.update) begin
         sum_in = sum_ff + SUM_BITS'(sample_ff) - old_term;
      end else if (cmd.sweep_step && pend_ff) begin
         sum_in = sum_ff + SUM_BITS'(rd_data_ff);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // restoring divider on the magnitude, one quotient bit per cycle
   logic [MAG_BITS-1:0]  dq_ff;
   logic [WIN_BITS-1:0]  rem_ff;
   logic                 neg_ff;
   logic [DCNT_BITS-1:0] div_cnt_ff;
   logic [WIN_BITS:0]    trial;
   logic [WIN_BITS:0]    trial_sub;
   logic                 trial_ge;
   logic [SUM_BITS-1:0]  sum_abs;

   assign sum_abs   = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
   assign trial     = {rem_ff, dq_ff[MAG_BITS-1]};
   assign trial_ge  = trial >= {1'b0, win_eff};
   assign trial_sub = trial - {1'b0, win_eff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dq_ff      <= sum_abs[MAG_BITS-1:0];
         neg_ff     <= sum_ff[SUM_BITS-1];
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         dq_ff      <= {dq_ff[MAG_BITS-2:0], trial_ge};
         rem_ff     <= trial_ge ? trial_sub[WIN_BITS-1:0] : trial[WIN_BITS-1:0];
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // result register
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] average_ff;
   logic [SAMPLE_BITS-1:0] quo_trunc;

   assign quo_trunc = dq_ff[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         average_ff <= neg_ff ? (~quo_trunc) + 1'b1 : quo_trunc;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = average_ff;

   always_comb begin
      status.dirty      = dirty_ff;
      status.sweep_done = !sweep_issue && !pend_ff;
      status.fill_ok    = fill_ff >= win_eff;
      status.div_done   = div_cnt_ff == DCNT_BITS'(MAG_BITS - 1);
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WIN_BITS'(MAX_WINDOW))
      else $error("fill count beyond ring depth");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      longint'(sum_ff) <= SUM_HI && longint'(sum_ff) >= SUM_LO)
      else $error("running sum outside the range of a full window");

   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (dq_ff >> (SAMPLE_BITS - 1)) == '0 ||
                   (neg_ff && dq_ff == (MAG_BITS'(1) << (SAMPLE_BITS - 1))))
      else $error("quotient does not fit the result field");

endmodule

`default_nettype wire

[rtl/sliding_window_average.sv]
// top level of the sliding window average block
//
// req_if takes one signed sample per transfer, rsp_if gives one average per
// transfer once at least window_len samples have arrived since reset; the
// earlier samples give no result. The average is the sum of the latest
// window_len samples divided by window_len, truncated toward zero.
// csr_write_en / csr_write_data set window_len (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW); write it only while the block is idle.
// Samples are handled one at a time. Each item passes through the update,
// load, bit-serial divide and emit steps from transfer to result; the next
// sample can be taken from the cycle the result appears. An item that gives
// no result ends after the update and load steps. The first item after a
// window length write also resums the ring over the latest W samples, W
// being the window length in force (all samples so far while fewer than W
// have arrived). A finished result waits in the output register, so a
// stalled receiver does not stop the next sample being taken; the block only
// waits when a second result is ready before the first is taken.
// Reset is synchronous: the window length returns to 4 and the fill count,
// sum and ring position clear, so no result comes until the window refills.
`default_nettype none

module sliding_window_average #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   swa_req_if.sink                      req_if,
   swa_rsp_if.source                    rsp_if,
   input  wire                          csr_write_en,
   input  wire [swa_pkg::CSR_BITS-1:0]  csr_write_data
);

   swa_pkg::cmd_type    cmd;
   swa_pkg::status_type status;
   logic                req_ready;
   logic                rsp_valid;
   logic signed [SAMPLE_BITS-1:0] rsp_average;

   swa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swa_datapath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_sample     (req_if.sample),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_valid),
      .rsp_average    (rsp_average)
   );

   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid;
   assign rsp_if.average = rsp_average;

endmodule

`default_nettype wire
